>>> design/assert_macros.svh
// assertion helpers for the pid position/velocity controller
// clocked on clk, disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every rising edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/pidc_pkg.sv
// shared types, constants and register map of the pid position/velocity controller
// no dependencies
package pidc_pkg;

  localparam int DATA_W        = 32;
  localparam int REG_W         = 32;
  localparam int LIM_W         = 31;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MUL_CHUNK     = 16;
  localparam int ADDR_W        = 5;

  typedef enum logic [2:0] {
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_SAMPLE_PERIOD,
    REG_INTEGRAL_LIMIT,
    REG_OUTPUT_LIMIT,
    REG_PD_SCALE,
    REG_DRIVE_SCALE
  } reg_idx_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_target;
    logic signed [DATA_W-1:0] pos_measured;
    logic signed [DATA_W-1:0] vel_target;
    logic signed [DATA_W-1:0] vel_measured;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive_command;
    logic signed [DATA_W-1:0] position_error;
  } out_item_t;

  typedef struct packed {
    logic signed [REG_W-1:0] gain_p;
    logic signed [REG_W-1:0] gain_i;
    logic signed [REG_W-1:0] gain_d;
    logic        [LIM_W-1:0] sample_period;
    logic        [LIM_W-1:0] integral_limit;
    logic        [LIM_W-1:0] output_limit;
    logic signed [REG_W-1:0] pd_scale;
    logic signed [REG_W-1:0] drive_scale;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    gain_p:         REG_W'(0),
    gain_i:         REG_W'(0),
    gain_d:         REG_W'(0),
    sample_period:  LIM_W'(65536),
    integral_limit: LIM_W'(65536000),
    output_limit:   LIM_W'(6553600),
    pd_scale:       REG_W'(65536),
    drive_scale:    REG_W'(65536)
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_W_INT,
    ST_M_P,
    ST_W_P,
    ST_M_I,
    ST_W_I,
    ST_W_DIV,
    ST_M_D,
    ST_W_D,
    ST_M_PD,
    ST_W_PD,
    ST_M_DRV,
    ST_W_DRV,
    ST_OUT
  } ctrl_state_t;

  // multiplier operand pairs
  typedef enum logic [2:0] {
    MS_INT,
    MS_P,
    MS_I,
    MS_D,
    MS_PD,
    MS_DRV
  } mul_sel_t;

  // where a finished product goes
  typedef enum logic [2:0] {
    CAP_INT,
    CAP_P,
    CAP_I,
    CAP_D,
    CAP_PD,
    CAP_DRV
  } cap_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     start_div;
    logic     start_mul;
    mul_sel_t mul_sel;
    logic     cap_en;
    cap_sel_t cap_sel;
    logic     commit;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_busy;
  } dp_status_t;

endpackage

>>> design/pidc_mul.sv
// sequential fixed point multiplier: wide signed operand times register operand,
// one 16-bit chunk per clock, floor shift by FRAC_BITS and saturation; uses pidc_pkg
module pidc_mul #(
  parameter int FRAC_BITS = pidc_pkg::FRAC_BITS_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           start,
  input  logic signed [pidc_pkg::DATA_W+FRAC_BITS-1:0]   op_a,
  input  logic signed [pidc_pkg::REG_W-1:0]              op_b,
  output logic                                           done,
  output logic signed [pidc_pkg::DATA_W+FRAC_BITS-1:0]   product
);
  import pidc_pkg::*;

  localparam int WIDE_W = DATA_W + FRAC_BITS;
  localparam int NCH    = (WIDE_W + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int EXT_W  = NCH * MUL_CHUNK;
  localparam int PROD_W = EXT_W + REG_W;
  localparam int SHR_W  = PROD_W - FRAC_BITS;
  localparam int PP_W   = MUL_CHUNK + 1 + REG_W;
  localparam int CNT_W  = $clog2(NCH);

  logic        [EXT_W-1:0]     a_r;
  logic signed [REG_W-1:0]     b_r;
  logic signed [PROD_W-1:0]    acc_r;
  logic        [CNT_W-1:0]     cnt_r;
  logic                        busy_r;
  logic                        first_r;
  logic                        fin_r;
  logic                        done_r;
  logic signed [WIDE_W-1:0]    prod_r;

  logic        [MUL_CHUNK-1:0] chunk;
  logic signed [MUL_CHUNK:0]   chunk_s;
  logic signed [PP_W-1:0]      pp;
  logic signed [PROD_W-1:0]    acc_nxt;
  logic        [SHR_W-1:0]     shr;
  logic                        ovf;
  logic signed [WIDE_W-1:0]    sat;

  // top chunk carries the sign, the rest are plain magnitudes
  assign chunk   = a_r[EXT_W-1 -: MUL_CHUNK];
  assign chunk_s = $signed({first_r & chunk[MUL_CHUNK-1], chunk});
  assign pp      = chunk_s * b_r;
  assign acc_nxt = (acc_r <<< MUL_CHUNK) + PROD_W'(pp);

  assign shr = SHR_W'(acc_r >>> FRAC_BITS);
  assign ovf = (shr[SHR_W-1:WIDE_W-1] != {(SHR_W-WIDE_W+1){shr[SHR_W-1]}});
  assign sat = ovf ? $signed({shr[SHR_W-1], {(WIDE_W-1){~shr[SHR_W-1]}}})
                   : $signed(shr[WIDE_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
      end
      fin_r  <= busy_r && cnt_r == '0;
      done_r <= fin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r     <= EXT_W'(op_a);
      b_r     <= op_b;
      acc_r   <= '0;
      cnt_r   <= CNT_W'(NCH - 1);
      first_r <= 1'b1;
    end else if (busy_r) begin
      a_r     <= a_r << MUL_CHUNK;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_r - 1'b1;
      first_r <= 1'b0;
    end
    if (fin_r) begin
      prod_r <= sat;
    end
  end

  assign done    = done_r;
  assign product = prod_r;

endmodule

>>> design/pidc_div.sv
// restoring divider for the derivative term: (diff << FRAC_BITS) / sample_period,
// one quotient bit per clock, truncated toward zero and saturated; uses pidc_pkg
module pidc_div #(
  parameter int FRAC_BITS = pidc_pkg::FRAC_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          start,
  input  logic signed [pidc_pkg::DATA_W:0]              diff,
  input  logic        [pidc_pkg::LIM_W-1:0]             divisor,
  output logic                                          busy,
  output logic signed [pidc_pkg::DATA_W+FRAC_BITS-1:0]  quotient
);
  import pidc_pkg::*;

  localparam int WIDE_W = DATA_W + FRAC_BITS;
  localparam int MAG_W  = DATA_W + 1;
  localparam int N_W    = MAG_W + FRAC_BITS;
  localparam int CNT_W  = $clog2(N_W + 1);

  logic        [N_W-1:0]    num_r;
  logic        [LIM_W-1:0]  rem_r;
  logic        [LIM_W-1:0]  div_r;
  logic        [CNT_W-1:0]  cnt_r;
  logic                     neg_r;
  logic                     zero_r;
  logic                     busy_r;
  logic                     fin_r;
  logic signed [WIDE_W-1:0] quo_r;

  logic        [MAG_W-1:0]  mag;
  logic        [LIM_W:0]    trial;
  logic                     fits;
  logic        [N_W-1:0]    q;
  logic                     pos_ovf;
  logic                     neg_ovf;
  logic signed [WIDE_W-1:0] sat;

  assign mag   = diff[DATA_W] ? MAG_W'(-diff) : MAG_W'(diff);
  assign trial = {rem_r, num_r[N_W-1]};
  assign fits  = trial >= {1'b0, div_r};

  // zero difference gives zero even when the period is zero
  assign q       = zero_r ? '0 : num_r;
  assign pos_ovf = |q[N_W-1:WIDE_W-1];
  assign neg_ovf = pos_ovf && (q != (N_W'(1) << (WIDE_W - 1)));

  always_comb begin
    if (neg_r) begin
      sat = neg_ovf ? $signed({1'b1, {(WIDE_W-1){1'b0}}}) : $signed(WIDE_W'(-q));
    end else begin
      sat = pos_ovf ? $signed({1'b0, {(WIDE_W-1){1'b1}}}) : $signed(q[WIDE_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
      fin_r <= busy_r && cnt_r == CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r  <= {mag, {FRAC_BITS{1'b0}}};
      rem_r  <= '0;
      div_r  <= divisor;
      cnt_r  <= CNT_W'(N_W);
      neg_r  <= diff[DATA_W];
      zero_r <= diff == '0;
    end else if (busy_r) begin
      // quotient bits shift in behind the numerator
      rem_r <= fits ? LIM_W'(trial - {1'b0, div_r}) : LIM_W'(trial);
      num_r <= {num_r[N_W-2:0], fits};
      cnt_r <= cnt_r - 1'b1;
    end
    if (fin_r) begin
      quo_r <= sat;
    end
  end

  assign busy     = busy_r | fin_r;
  assign quotient = quo_r;

endmodule

>>> design/pidc_dp.sv
// datapath: error terms, integral state, shared multiplier and divider, result register
// uses pidc_pkg, pidc_mul and pidc_div
module pidc_dp #(
  parameter int FRAC_BITS = pidc_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pidc_pkg::dp_cmd_t     cmd,
  output pidc_pkg::dp_status_t  sts,
  input  pidc_pkg::in_item_t    in_data,
  input  pidc_pkg::cfg_t        cfg,
  output pidc_pkg::out_item_t   out_data
);
  import pidc_pkg::*;

  localparam int WIDE_W = DATA_W + FRAC_BITS;

  logic signed [DATA_W-1:0] pe_r;
  logic signed [DATA_W-1:0] ve_r;
  logic signed [DATA_W-1:0] prev_pe_r;
  logic signed [DATA_W-1:0] prev_ve_r;
  logic signed [REG_W-1:0]  isum_r;
  logic signed [REG_W-1:0]  isum_new_r;
  logic signed [WIDE_W-1:0] pterm_r;
  logic signed [WIDE_W-1:0] iterm_r;
  logic signed [WIDE_W-1:0] pd_r;
  logic signed [WIDE_W-1:0] drv_r;
  logic signed [DATA_W-1:0] drive_r;
  out_item_t                out_r;

  logic signed [DATA_W:0]   pos_diff;
  logic signed [DATA_W:0]   vel_diff;
  logic signed [DATA_W:0]   avg_sum;
  logic signed [DATA_W-1:0] avg;
  logic signed [DATA_W:0]   err_diff;
  logic signed [WIDE_W-1:0] mul_a;
  logic signed [REG_W-1:0]  mul_b;
  logic                     mul_done;
  logic signed [WIDE_W-1:0] mul_prod;
  logic                     div_busy;
  logic signed [WIDE_W-1:0] deriv;
  logic signed [WIDE_W:0]   isum_sum;
  logic signed [WIDE_W:0]   ilim_w;
  logic signed [REG_W-1:0]  isum_clamp;
  logic signed [WIDE_W-1:0] olim_w;
  logic signed [DATA_W-1:0] drive_clamp;

  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [DATA_W:0] v);
    if (v[DATA_W] != v[DATA_W-1]) begin
      return {v[DATA_W], {(DATA_W-1){~v[DATA_W]}}};
    end
    return v[DATA_W-1:0];
  endfunction

  function automatic logic signed [WIDE_W-1:0] sat_wide(input logic signed [WIDE_W:0] v);
    if (v[WIDE_W] != v[WIDE_W-1]) begin
      return {v[WIDE_W], {(WIDE_W-1){~v[WIDE_W]}}};
    end
    return v[WIDE_W-1:0];
  endfunction

  assign pos_diff = (DATA_W+1)'(in_data.pos_target) - (DATA_W+1)'(in_data.pos_measured);
  assign vel_diff = (DATA_W+1)'(in_data.vel_target) - (DATA_W+1)'(in_data.vel_measured);

  // trapezoid average, floor of half the sum
  assign avg_sum  = (DATA_W+1)'(prev_pe_r) + (DATA_W+1)'(pe_r);
  assign avg      = avg_sum[DATA_W:1];
  assign err_diff = (DATA_W+1)'(ve_r) - (DATA_W+1)'(prev_ve_r);

  always_comb begin
    case (cmd.mul_sel)
      MS_INT: begin
        mul_a = WIDE_W'(avg);
        mul_b = $signed({1'b0, cfg.sample_period});
      end
      MS_P: begin
        mul_a = WIDE_W'(pe_r);
        mul_b = cfg.gain_p;
      end
      MS_I: begin
        mul_a = WIDE_W'(isum_new_r);
        mul_b = cfg.gain_i;
      end
      MS_D: begin
        mul_a = deriv;
        mul_b = cfg.gain_d;
      end
      MS_PD: begin
        mul_a = pd_r;
        mul_b = cfg.pd_scale;
      end
      MS_DRV: begin
        mul_a = drv_r;
        mul_b = cfg.drive_scale;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pidc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.start_mul),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .done    (mul_done),
    .product (mul_prod)
  );

  pidc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.start_div),
    .diff     (err_diff),
    .divisor  (cfg.sample_period),
    .busy     (div_busy),
    .quotient (deriv)
  );

  // anti-windup clamp of the integral
  assign isum_sum = (WIDE_W+1)'(isum_r) + (WIDE_W+1)'(mul_prod);
  assign ilim_w   = $signed((WIDE_W+1)'(cfg.integral_limit));

  always_comb begin
    if (isum_sum > ilim_w) begin
      isum_clamp = REG_W'(ilim_w);
    end else if (isum_sum < -ilim_w) begin
      isum_clamp = REG_W'(-ilim_w);
    end else begin
      isum_clamp = REG_W'(isum_sum);
    end
  end

  assign olim_w = $signed(WIDE_W'(cfg.output_limit));

  always_comb begin
    if (mul_prod > olim_w) begin
      drive_clamp = DATA_W'(olim_w);
    end else if (mul_prod < -olim_w) begin
      drive_clamp = DATA_W'(-olim_w);
    end else begin
      drive_clamp = DATA_W'(mul_prod);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      isum_r    <= '0;
      prev_pe_r <= '0;
      prev_ve_r <= '0;
    end else if (cmd.commit) begin
      isum_r    <= isum_new_r;
      prev_pe_r <= pe_r;
      prev_ve_r <= ve_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      pe_r <= sat_data(pos_diff);
      ve_r <= sat_data(vel_diff);
    end
    if (cmd.cap_en) begin
      case (cmd.cap_sel)
        CAP_INT: isum_new_r <= isum_clamp;
        CAP_P:   pterm_r    <= mul_prod;
        CAP_I:   iterm_r    <= mul_prod;
        CAP_D:   pd_r       <= sat_wide((WIDE_W+1)'(pterm_r) + (WIDE_W+1)'(mul_prod));
        CAP_PD:  drv_r      <= sat_wide((WIDE_W+1)'(mul_prod) + (WIDE_W+1)'(iterm_r));
        CAP_DRV: drive_r    <= drive_clamp;
        default: ;
      endcase
    end
    if (cmd.commit) begin
      out_r.drive_command  <= drive_r;
      out_r.position_error <= pe_r;
    end
  end

  assign sts.mul_done = mul_done;
  assign sts.div_busy = div_busy;
  assign out_data     = out_r;

endmodule

>>> design/pidc_ctrl.sv
// controller: sequences the multiplies and the divide for one beat, owns the handshakes
// uses pidc_pkg
module pidc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  pidc_pkg::dp_status_t  sts,
  output pidc_pkg::dp_cmd_t     cmd
);
  import pidc_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_PREP;
      ST_PREP:  state_nxt = ST_W_INT;
      ST_W_INT: if (sts.mul_done) state_nxt = ST_M_P;
      ST_M_P:   state_nxt = ST_W_P;
      ST_W_P:   if (sts.mul_done) state_nxt = ST_M_I;
      ST_M_I:   state_nxt = ST_W_I;
      ST_W_I:   if (sts.mul_done) state_nxt = ST_W_DIV;
      ST_W_DIV: if (!sts.div_busy) state_nxt = ST_M_D;
      ST_M_D:   state_nxt = ST_W_D;
      ST_W_D:   if (sts.mul_done) state_nxt = ST_M_PD;
      ST_M_PD:  state_nxt = ST_W_PD;
      ST_W_PD:  if (sts.mul_done) state_nxt = ST_M_DRV;
      ST_M_DRV: state_nxt = ST_W_DRV;
      ST_W_DRV: if (sts.mul_done) state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.mul_sel   = MS_INT;
    cmd.cap_sel   = CAP_INT;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_PREP: begin
        // divide runs alongside the integral, P and I products
        cmd.start_div = 1'b1;
        cmd.start_mul = 1'b1;
        cmd.mul_sel   = MS_INT;
      end
      ST_W_INT: begin
        cmd.cap_en  = sts.mul_done;
        cmd.cap_sel = CAP_INT;
      end
      ST_M_P: begin
        cmd.start_mul = 1'b1;
        cmd.mul_sel   = MS_P;
      end
      ST_W_P: begin
        cmd.cap_en  = sts.mul_done;
        cmd.cap_sel = CAP_P;
      end
      ST_M_I: begin
        cmd.start_mul = 1'b1;
        cmd.mul_sel   = MS_I;
      end
      ST_W_I: begin
        cmd.cap_en  = sts.mul_done;
        cmd.cap_sel = CAP_I;
      end
      ST_W_DIV: ;
      ST_M_D: begin
        cmd.start_mul = 1'b1;
        cmd.mul_sel   = MS_D;
      end
      ST_W_D: begin
        cmd.cap_en  = sts.mul_done;
        cmd.cap_sel = CAP_D;
      end
      ST_M_PD: begin
        cmd.start_mul = 1'b1;
        cmd.mul_sel   = MS_PD;
      end
      ST_W_PD: begin
        cmd.cap_en  = sts.mul_done;
        cmd.cap_sel = CAP_PD;
      end
      ST_M_DRV: begin
        cmd.start_mul = 1'b1;
        cmd.mul_sel   = MS_DRV;
      end
      ST_W_DRV: begin
        cmd.cap_en  = sts.mul_done;
        cmd.cap_sel = CAP_DRV;
      end
      ST_OUT: begin
        cmd.commit = out_free;
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = cmd.commit | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> design/pid_position_velocity_controller.sv
// top level: apb register file, controller and datapath of the pid controller
// uses pidc_pkg, pidc_ctrl, pidc_dp and assert_macros.svh
//
// PID position/velocity controller with integral anti-windup, signed Q16.16 in and out.
// Each input beat (target and measured position and velocity) gives one result beat:
// the drive command, clamped to plus or minus output_limit, and the saturated position
// error. Beats are handled one at a time. The bit-serial derivative divider forms
// a quotient of N = 33 + FRAC_BITS bits, one bit per clock, and the shared multiplier
// takes its 32+FRAC_BITS wide operand in 16-bit chunks. The integral, P and I
// products run on the shared multiplier while the divider works; the D, filter and
// output products follow it. A new beat can be taken while the previous result
// still waits on out_ready. Registers sit at byte address 4*i in the order gain_p,
// gain_i, gain_d, sample_period, integral_limit, output_limit, pd_scale, drive_scale.
// The user must write them only while the block is idle; the block does not enforce it.
`include "assert_macros.svh"

module pid_position_velocity_controller #(
  parameter int FRAC_BITS = pidc_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pidc_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pidc_pkg::out_item_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pidc_pkg::ADDR_W-1:0]   paddr,
  input  logic [pidc_pkg::REG_W-1:0]    pwdata,
  output logic [pidc_pkg::REG_W-1:0]    prdata,
  output logic                          pready
);
  import pidc_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  reg_idx_t   reg_idx;
  logic       wr_en;
  dp_cmd_t    cmd;
  dp_status_t sts;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_GAIN_P:         cfg_nxt.gain_p         = $signed(pwdata);
        REG_GAIN_I:         cfg_nxt.gain_i         = $signed(pwdata);
        REG_GAIN_D:         cfg_nxt.gain_d         = $signed(pwdata);
        REG_SAMPLE_PERIOD:  cfg_nxt.sample_period  = pwdata[LIM_W-1:0];
        REG_INTEGRAL_LIMIT: cfg_nxt.integral_limit = pwdata[LIM_W-1:0];
        REG_OUTPUT_LIMIT:   cfg_nxt.output_limit   = pwdata[LIM_W-1:0];
        REG_PD_SCALE:       cfg_nxt.pd_scale       = $signed(pwdata);
        REG_DRIVE_SCALE:    cfg_nxt.drive_scale    = $signed(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GAIN_P:         prdata = cfg_r.gain_p;
      REG_GAIN_I:         prdata = cfg_r.gain_i;
      REG_GAIN_D:         prdata = cfg_r.gain_d;
      REG_SAMPLE_PERIOD:  prdata = {1'b0, cfg_r.sample_period};
      REG_INTEGRAL_LIMIT: prdata = {1'b0, cfg_r.integral_limit};
      REG_OUTPUT_LIMIT:   prdata = {1'b0, cfg_r.output_limit};
      REG_PD_SCALE:       prdata = cfg_r.pd_scale;
      REG_DRIVE_SCALE:    prdata = cfg_r.drive_scale;
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pidc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pidc_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .out_data (out_data)
  );

  // one beat in flight at a time
  `ASSERT_CLK(a_single_beat, (in_valid && in_ready) |=> !in_ready, "beat accepted while busy")
  // a result never overwrites one that has not been taken
  `ASSERT_CLK(a_no_overwrite, cmd.commit |-> (!out_valid || out_ready), "result overwritten")
  `ASSERT_CLK(a_commit_shows, cmd.commit |=> out_valid, "committed result not presented")
  // divider is idle whenever a new divide is launched
  `ASSERT_CLK(a_div_idle, cmd.start_div |-> !sts.div_busy, "divide started while busy")

endmodule
